### hw/rtl/btp_pkg.sv
// ----------------------------------------------------------------------------
// btp_pkg
// Types and constants shared by the BER TLV header parser modules.
// ----------------------------------------------------------------------------
package btp_pkg;

  // longest long-form length field, in bytes after the 0x8n byte
  localparam int unsigned MAX_LEN_BYTES = 4;

  // phase of header parsing
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN1 = 2'd1,
    PH_LONG = 2'd2
  } phase_t;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  held_tag;
    logic [31:0] length_accum;
    logic [2:0]  length_bytes_left;
    logic [2:0]  header_count;
    logic [31:0] avail_held;
  } parse_state_t;

  // one decoded header result
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag_byte;
    logic [31:0] value_length;
    logic [2:0]  header_length;
    logic [31:0] total_length;
    logic        constructed;
  } result_t;

endpackage

### hw/rtl/btp_decode.sv
// ----------------------------------------------------------------------------
// btp_decode
// Next-state and result logic for one byte of a BER element header.
// ----------------------------------------------------------------------------
module btp_decode
  import btp_pkg::*;
(
  input  parse_state_t state,
  input  logic [7:0]   byte_value,
  input  logic         start_flag,
  input  logic [31:0]  avail_len,
  output parse_state_t state_nxt,
  output logic         emit,
  output result_t      result
);

  logic [6:0]  len_count;
  logic [31:0] accum_shift;
  logic [2:0]  left_dec;
  logic [2:0]  hc_inc;
  logic        do_final;
  logic [31:0] final_vlen;
  logic [2:0]  final_hc;
  logic [32:0] final_total;
  logic        final_fits;
  logic [32:0] long_need;
  logic [1:0]  err_code;
  logic        do_error;

  assign len_count   = byte_value[6:0];
  assign accum_shift = {state.length_accum[23:0], byte_value};
  assign left_dec    = (state.length_bytes_left != 3'd0) ?
                       state.length_bytes_left - 3'd1 : 3'd0;
  assign hc_inc      = state.header_count + 3'd1;
  assign long_need   = 33'd2 + {26'd0, len_count};

  // shared total length and buffer fit check
  assign final_total = {30'd0, final_hc} + {1'b0, final_vlen};
  assign final_fits  = final_total <= {1'b0, state.avail_held};

  // state update and result selection
  always_comb begin
    state_nxt  = state;
    do_final   = 1'b0;
    do_error   = 1'b0;
    err_code   = ST_OK;
    final_vlen = {24'd0, byte_value};
    final_hc   = 3'd2;
    if (start_flag) begin
      state_nxt.held_tag          = byte_value;
      state_nxt.avail_held        = avail_len;
      state_nxt.length_accum      = 32'd0;
      state_nxt.length_bytes_left = 3'd0;
      state_nxt.header_count      = 3'd1;
      if (avail_len < 32'd2) begin
        do_error = 1'b1;
        err_code = ST_SHORT;
      end else begin
        state_nxt.phase = PH_LEN1;
      end
    end else begin
      unique case (state.phase)
        PH_LEN1: begin
          state_nxt.header_count = 3'd2;
          if (!byte_value[7]) begin
            do_final = 1'b1;
          end else if (len_count == 7'd0 || len_count > 7'(MAX_LEN_BYTES)) begin
            do_error = 1'b1;
            err_code = ST_BADLEN;
          end else if ({1'b0, state.avail_held} < long_need) begin
            do_error = 1'b1;
            err_code = ST_SHORT;
          end else begin
            state_nxt.length_accum      = 32'd0;
            state_nxt.length_bytes_left = len_count[2:0];
            state_nxt.phase             = PH_LONG;
          end
        end
        PH_LONG: begin
          state_nxt.length_accum      = accum_shift;
          state_nxt.header_count      = hc_inc;
          state_nxt.length_bytes_left = left_dec;
          final_vlen                  = accum_shift;
          final_hc                    = hc_inc;
          if (left_dec == 3'd0) begin
            do_final = 1'b1;
          end
        end
        default: begin
          state_nxt.phase = PH_IDLE;
        end
      endcase
    end

    // a header that overruns the buffer turns into an error
    if (do_final && !final_fits) begin
      do_error = 1'b1;
      err_code = ST_BADLEN;
    end
    if (do_final || do_error) begin
      state_nxt.phase = PH_IDLE;
    end
  end

  // result fields
  always_comb begin
    emit   = do_final || do_error;
    result = '0;
    if (do_error) begin
      result.status = err_code;
    end else begin
      result.status        = ST_OK;
      result.tag_byte      = state.held_tag;
      result.value_length  = final_vlen;
      result.header_length = final_hc;
      result.total_length  = final_total[31:0];
      result.constructed   = state.held_tag[5];
    end
  end

endmodule

### hw/rtl/ber_tlv_header_parser.sv
// ----------------------------------------------------------------------------
// ber_tlv_header_parser
// Decodes the tag and length header of a BER element, one byte per
// transaction, and gives one result per header or error.
// ----------------------------------------------------------------------------
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, in_byte_value, in_start_flag,| in
//          | in_avail_len                                    |
//  result  | out_valid, out_stall, out_status, out_tag_byte,  | out
//          | out_value_length, out_header_length,            |
//          | out_total_length, out_constructed               |
//
//  One byte per cycle sustained unless a held result stalls the input. A byte
//  waits in the input register, then the parse logic updates state and loads
//  the result register, which holds the result and its valid flag.
//  Synchronous active-low reset clears the parse state and both valid flags.
//  A held result stalls the input register only while a new byte waits in it.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser
  import btp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_start_flag,
  input  logic [31:0] in_avail_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_tag_byte,
  output logic [31:0] out_value_length,
  output logic [2:0]  out_header_length,
  output logic [31:0] out_total_length,
  output logic        out_constructed
);

  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_start_r;
  logic [31:0]  s1_avail_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         emit;
  result_t      result;
  result_t      out_r;
  logic         out_valid_r;
  logic         s2_free;
  logic         s1_go;

  // handshake between stages
  assign s2_free  = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_byte_value;
      s1_start_r <= in_start_flag;
      s1_avail_r <= in_avail_len;
    end
  end

  // parse logic
  btp_decode u_decode (
    .state      (state_r),
    .byte_value (s1_byte_r),
    .start_flag (s1_start_r),
    .avail_len  (s1_avail_r),
    .state_nxt  (state_nxt),
    .emit       (emit),
    .result     (result)
  );

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, default: '0};
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_tag_byte      = out_r.tag_byte;
  assign out_value_length  = out_r.value_length;
  assign out_header_length = out_r.header_length;
  assign out_total_length  = out_r.total_length;
  assign out_constructed   = out_r.constructed;

endmodule
